// ----- rtl/reorder_buffer_cumulative_ack_unit_defines.svh -----
// Assertion macros shared by the reorder buffer RTL.
`ifndef REORDER_BUFFER_CUMULATIVE_ACK_UNIT_DEFINES_SVH
`define REORDER_BUFFER_CUMULATIVE_ACK_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RBCA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("reorder buffer check failed");

// Next-cycle implication, checked outside reset.
`define RBCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("reorder buffer check failed");

`endif

// ----- rtl/rbca_pkg.sv -----
// Types and constants of the reorder buffer with cumulative ack.
package rbca_pkg;

  localparam int WINDOW = 32;
  localparam int SLOT_W = $clog2(WINDOW);

  localparam int CFG_AW = 3;
  localparam logic [15:0] IDLE_LIMIT_RST = 16'd60;
  localparam logic REG_IDLE_LIMIT = 1'b0;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] seq;
    logic [15:0] payload_tag;
    logic [14:0] payload_len;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] out_tag;
    logic [14:0] out_len;
    logic [31:0] ack_seq;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [14:0] len;
  } slot_entry_t;

  typedef struct packed {
    logic sess_open;
    logic any_full;
  } seq_status_t;

endpackage

// ----- rtl/rbca_slot_mem.sv -----
// Slot store: parked payload handles and lengths, one write and one registered read port.
module rbca_slot_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [rbca_pkg::SLOT_W-1:0] waddr,
  input  rbca_pkg::slot_entry_t      wdata,
  input  logic                       re,
  input  logic [rbca_pkg::SLOT_W-1:0] raddr,
  output rbca_pkg::slot_entry_t      rdata
);
  import rbca_pkg::*;

  slot_entry_t mem [WINDOW];
  slot_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rbca_seq.sv -----
// Sequencer: session state, slot flags, park and drain over the slot store.
module rbca_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           idle_limit,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rbca_pkg::in_item_t    in_data,
  input  logic                  emit_ok,
  output logic                  emit,
  output rbca_pkg::result_t     result,
  output rbca_pkg::seq_status_t status
);
  import rbca_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_DELIVER = 2'd1;
  localparam logic [1:0] ST_DRAIN   = 2'd2;
  localparam logic [1:0] ST_ACK     = 2'd3;

  localparam logic [SLOT_W-1:0] HEAD_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [SLOT_W:0]   WIN_SUM   = (SLOT_W + 1)'(WINDOW);

  logic [1:0]        state_r, state_nxt;
  logic [31:0]       next_exp_r, next_exp_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [WINDOW-1:0] full_r, full_nxt;
  logic [15:0]       idle_r, idle_nxt;
  logic              open_r, open_nxt;
  logic [15:0]       tag_r, tag_nxt;
  logic [14:0]       len_r, len_nxt;

  logic              accept;
  logic [SLOT_W-1:0] head_inc;
  logic [31:0]       seq_gap;
  logic              in_win;
  logic [SLOT_W:0]   park_sum;
  logic [SLOT_W-1:0] park_slot;
  logic [15:0]       idle_cnt;

  logic              mem_we;
  logic              mem_re;
  slot_entry_t       mem_wdata;
  slot_entry_t       mem_rdata;

  rbca_slot_mem u_slot_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (park_slot),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (head_inc),
    .rdata (mem_rdata)
  );

  assign in_stall = !((state_r == ST_IDLE) || ((state_r == ST_ACK) && emit_ok));
  assign accept   = in_valid && !in_stall;
  assign head_inc = (head_r == HEAD_LAST) ? '0 : head_r + SLOT_W'(1);

  assign seq_gap   = in_data.seq - next_exp_r;
  assign in_win    = (seq_gap != 32'd0) && (seq_gap < 32'(WINDOW));
  assign park_sum  = {1'b0, head_r} + {1'b0, seq_gap[SLOT_W-1:0]};
  assign park_slot = (park_sum >= WIN_SUM) ? SLOT_W'(park_sum - WIN_SUM)
                                           : park_sum[SLOT_W-1:0];
  assign idle_cnt  = (idle_r != 16'hFFFF) ? idle_r + 16'd1 : idle_r;

  assign mem_wdata.tag = in_data.payload_tag;
  assign mem_wdata.len = in_data.payload_len;

  assign status.sess_open = open_r;
  assign status.any_full  = |full_r;

  always_comb begin
    state_nxt    = state_r;
    next_exp_nxt = next_exp_r;
    head_nxt     = head_r;
    full_nxt     = full_r;
    idle_nxt     = idle_r;
    open_nxt     = open_r;
    tag_nxt      = tag_r;
    len_nxt      = len_r;
    emit         = 1'b0;
    result       = '0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;

    case (state_r)
      ST_IDLE, ST_ACK: begin
        if ((state_r == ST_ACK) && emit_ok) begin
          emit           = 1'b1;
          result.kind    = KIND_ACK;
          result.ack_seq = next_exp_r - 32'd1;
          result.last    = 1'b1;
          state_nxt      = ST_IDLE;
        end
        if (accept) begin
          if (in_data.cmd == CMD_TICK) begin
            if (open_r) begin
              if (idle_cnt >= idle_limit) begin
                next_exp_nxt = '0;
                head_nxt     = '0;
                full_nxt     = '0;
                idle_nxt     = '0;
                open_nxt     = 1'b0;
              end else begin
                idle_nxt = idle_cnt;
              end
            end
          end else begin
            open_nxt = 1'b1;
            idle_nxt = '0;
            tag_nxt  = in_data.payload_tag;
            len_nxt  = in_data.payload_len;
            if (seq_gap == 32'd0) begin
              state_nxt = ST_DELIVER;
            end else begin
              // park in the ring slot if inside the window, unless a first copy already sits there
              if (in_win && !full_r[park_slot]) begin
                mem_we              = 1'b1;
                full_nxt[park_slot] = 1'b1;
              end
              state_nxt = ST_ACK;
            end
          end
        end
      end
      ST_DELIVER: begin
        if ((len_r == 15'd0) || emit_ok) begin
          emit           = (len_r != 15'd0);
          result.kind    = KIND_DELIVER;
          result.out_tag = tag_r;
          result.out_len = len_r;
          next_exp_nxt   = next_exp_r + 32'd1;
          head_nxt       = head_inc;
          mem_re         = 1'b1;
          state_nxt      = full_r[head_inc] ? ST_DRAIN : ST_ACK;
        end
      end
      ST_DRAIN: begin
        if ((mem_rdata.len == 15'd0) || emit_ok) begin
          emit             = (mem_rdata.len != 15'd0);
          result.kind      = KIND_DELIVER;
          result.out_tag   = mem_rdata.tag;
          result.out_len   = mem_rdata.len;
          full_nxt[head_r] = 1'b0;
          next_exp_nxt     = next_exp_r + 32'd1;
          head_nxt         = head_inc;
          mem_re           = 1'b1;
          state_nxt        = full_r[head_inc] ? ST_DRAIN : ST_ACK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      next_exp_r <= '0;
      head_r     <= '0;
      full_r     <= '0;
      idle_r     <= '0;
      open_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      next_exp_r <= next_exp_nxt;
      head_r     <= head_nxt;
      full_r     <= full_nxt;
      idle_r     <= idle_nxt;
      open_r     <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    len_r <= len_nxt;
  end

endmodule

// ----- rtl/reorder_buffer_cumulative_ack_unit.sv -----
// Top level of the reorder buffer: request channels, config port, result register.
// Receiver reorder buffer for one sliding-window session.
// Input channel (in_valid / in_stall / in_data): each request is either a data
// packet (sequence number, payload handle, length) or an idle tick. A data
// packet yields zero or more in-order deliveries followed by one cumulative
// ack (last = 1). Ticks yield nothing.
// Result channel (out_valid / out_stall / out_data): one registered result
// stage; a new result loads as the held one leaves, so the request side keeps
// working while a result waits.
// Timing: an in-order packet passes through acceptance and then delivery, the ack
// overlapping with acceptance of the next request; a parked, duplicate or
// out-of-window packet goes straight to the ack state, and a tick leaves the
// sequencer idle. Each parked successor drained after a gap takes a pass through
// the drain state, paced by the registered read of the slot store, which is read
// one slot ahead of the drain.
// While the receiver stalls, results hold in the output register and the
// sequencer waits; zero-length payloads advance without a result.
// Reset: expected sequence 0, all slots empty, session closed, idle_limit 60.
// idle_limit sits at APB byte address 0.
module reorder_buffer_cumulative_ack_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rbca_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rbca_pkg::result_t               out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbca_pkg::CFG_AW-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import rbca_pkg::*;
`include "reorder_buffer_cumulative_ack_unit_defines.svh"

  logic [15:0] idle_limit_r, idle_limit_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_data_r;
  logic        emit_ok;
  logic        emit;
  result_t     result;
  seq_status_t status;
  logic        cfg_wr;
  logic        deliver_out;
  logic        data_accept;

  // config port: single register, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_IDLE_LIMIT) ? {16'd0, idle_limit_r} : 32'd0;

  always_comb begin
    idle_limit_nxt = idle_limit_r;
    if (cfg_wr && (paddr[2] == REG_IDLE_LIMIT)) begin
      idle_limit_nxt = pwdata[15:0];
    end
  end

  rbca_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .idle_limit (idle_limit_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .emit_ok    (emit_ok),
    .emit       (emit),
    .result     (result),
    .status     (status)
  );

  // load a new result when the register is empty or its result leaves now
  assign emit_ok = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_limit_r <= IDLE_LIMIT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      idle_limit_r <= idle_limit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign deliver_out = out_valid_r && (out_data_r.kind == KIND_DELIVER);
  assign data_accept = in_valid && !in_stall && (in_data.cmd == CMD_DATA);

  `RBCA_ASSERT_IMPL(a_emit_room, clk, rst_n, emit, !out_valid_r || !out_stall)
  `RBCA_ASSERT_IMPL(a_deliver_nonzero, clk, rst_n, deliver_out, out_data_r.out_len != 15'd0)
  `RBCA_ASSERT_IMPL(a_closed_empty, clk, rst_n, !status.sess_open, !status.any_full)
  `RBCA_ASSERT_NEXT(a_data_opens, clk, rst_n, data_accept, status.sess_open)

endmodule

// ----- bench/rbca_checker.sv -----
// Channel monitor, receiver predictor and result comparison for the reorder buffer.
`timescale 1ns / 1ps

module rbca_checker
  import rbca_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  result_t             out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output int                  wrong_results,
  output int                  awaited_count
);

  localparam logic [CFG_AW-1:0] IDLE_LIMIT_ADDR = CFG_AW'(4 * int'(REG_IDLE_LIMIT));
  localparam int REPORT_LIMIT = 10;

  // Receiver state as the block should hold it
  logic [15:0]  idle_limit;
  logic [31:0]  next_expected;
  logic [15:0]  idle_ticks;
  logic         sess_open;
  int unsigned  ring_head;
  logic         slot_full [WINDOW];
  logic [15:0]  slot_tag  [WINDOW];
  logic [14:0]  slot_len  [WINDOW];

  result_t      awaited_results [$];
  int           fault_total;
  int           result_index;

  function automatic void clear_session();
    next_expected = '0;
    idle_ticks    = '0;
    ring_head     = 0;
    sess_open     = 1'b0;
    foreach (slot_full[i]) slot_full[i] = 1'b0;
  endfunction

  function automatic void advance_expected();
    next_expected = next_expected + 32'd1;
    ring_head     = (ring_head + 1) % WINDOW;
  endfunction

  function automatic result_t form_result(logic kind, logic [15:0] tag, logic [14:0] len);
    result_t r;
    r.kind    = kind;
    r.out_tag = (kind == KIND_ACK) ? 16'd0 : tag;
    r.out_len = (kind == KIND_ACK) ? 15'd0 : len;
    r.ack_seq = (kind == KIND_ACK) ? next_expected - 32'd1 : 32'd0;
    r.last    = (kind == KIND_ACK);
    return r;
  endfunction

  task automatic predict_results(input in_item_t req);
    logic [31:0] ahead;
    int unsigned slot;
    if (req.cmd == CMD_TICK) begin
      if (sess_open) begin
        if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
        if (idle_ticks >= idle_limit) clear_session();
      end
      return;
    end
    sess_open  = 1'b1;
    idle_ticks = '0;
    ahead = req.seq - next_expected;
    if (ahead == 32'd0) begin
      if (req.payload_len != '0)
        awaited_results.push_back(form_result(KIND_DELIVER, req.payload_tag, req.payload_len));
      advance_expected();
      // drain parked successors up to the first gap
      while (slot_full[ring_head]) begin
        if (slot_len[ring_head] != '0)
          awaited_results.push_back(form_result(KIND_DELIVER, slot_tag[ring_head],
                                                slot_len[ring_head]));
        slot_full[ring_head] = 1'b0;
        advance_expected();
      end
    end else if (ahead < 32'(WINDOW)) begin
      slot = (ring_head + ahead) % WINDOW;
      if (!slot_full[slot]) begin
        slot_full[slot] = 1'b1;
        slot_tag[slot]  = req.payload_tag;
        slot_len[slot]  = req.payload_len;
      end
    end
    awaited_results.push_back(form_result(KIND_ACK, '0, '0));
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      idle_limit = IDLE_LIMIT_RST;
      clear_session();
      awaited_results.delete();
      fault_total  = 0;
      result_index = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == IDLE_LIMIT_ADDR)
        idle_limit = pwdata[15:0];

      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          if (fault_total < REPORT_LIMIT)
            $display("result %0d arrived with none awaited: kind=%0d tag=%h len=%0d ack=%h last=%0d",
                     result_index, out_data.kind, out_data.out_tag, out_data.out_len,
                     out_data.ack_seq, out_data.last);
          fault_total++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data.kind !== want.kind || out_data.out_tag !== want.out_tag ||
              out_data.out_len !== want.out_len || out_data.ack_seq !== want.ack_seq ||
              out_data.last !== want.last) begin
            if (fault_total < REPORT_LIMIT)
              $display("result %0d wrong: want kind=%0d tag=%h len=%0d ack=%h last=%0d, got kind=%0d tag=%h len=%0d ack=%h last=%0d",
                       result_index, want.kind, want.out_tag, want.out_len, want.ack_seq,
                       want.last, out_data.kind, out_data.out_tag, out_data.out_len,
                       out_data.ack_seq, out_data.last);
            fault_total++;
          end
        end
        result_index++;
      end

      if (in_valid && !in_stall) predict_results(in_data);
    end
    wrong_results <= fault_total;
    awaited_count <= awaited_results.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// Stimulus, clock, reset and verdict for the reorder buffer bench.
`timescale 1ns / 1ps

module tb_top;
  import rbca_pkg::*;

  localparam logic [CFG_AW-1:0] IDLE_LIMIT_ADDR = CFG_AW'(4 * int'(REG_IDLE_LIMIT));
  localparam int DRAIN_CYCLES = 8;        // wait after the last result for the block to go quiet
  localparam int CYCLE_LIMIT  = 400000;   // watchdog bound on the run
  localparam int PHASE_ITEMS  = 52;       // data requests per random phase

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall = 1'b0;
  result_t             out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int                  wrong_results;
  int                  awaited_count;

  // Idle rates of both sides, in percent
  int                  send_idle_pct = 17;
  int                  recv_idle_pct = 48;

  // Shadow of the session, just enough to keep packet sequences well formed
  logic [31:0]         stream_base  = '0;
  bit                  stream_open  = 1'b0;
  int                  quiet_ticks  = 0;
  logic [15:0]         cur_idle_limit = IDLE_LIMIT_RST;
  int                  data_sent    = 0;
  int                  cycle_count  = 0;

  // Idle limits per random phase, extremes included
  logic [15:0] limit_plan [6] = '{16'hFFFF, 16'd1, 16'd7, 16'd60, 16'd2, 16'hFFFF};

  reorder_buffer_cumulative_ack_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  rbca_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .wrong_results (wrong_results),
    .awaited_count (awaited_count)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random; a stall may start or end on any cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("reorder_buffer_cumulative_ack_unit: mismatch");
      $finish;
    end
  end

  // Offer one request, with a random gap ahead of it, and hold it until taken.
  // Called and returning at a falling edge; valid stays high on return so
  // back-to-back requests never drop it within one step.
  task automatic issue_request(input in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [31:0] seq, input logic [15:0] tag,
                             input logic [14:0] len);
    in_item_t req;
    req.cmd         = CMD_DATA;
    req.seq         = seq;
    req.payload_tag = tag;
    req.payload_len = len;
    issue_request(req);
    stream_open = 1'b1;
    quiet_ticks = 0;
    data_sent++;
  endtask

  // Send idle ticks; flag when they close the session so the stream restarts at zero.
  task automatic send_ticks(input int count, output bit closed);
    in_item_t req;
    closed = 1'b0;
    repeat (count) begin
      req.cmd         = CMD_TICK;
      req.seq         = $urandom;
      req.payload_tag = 16'($urandom);
      req.payload_len = 15'($urandom);
      issue_request(req);
      if (stream_open) begin
        quiet_ticks++;
        if (quiet_ticks >= cur_idle_limit) begin
          stream_open = 1'b0;
          quiet_ticks = 0;
          stream_base = '0;
          closed      = 1'b1;
        end
      end
    end
  endtask

  // Drop valid and hold off until every awaited result is out and the block is quiet.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write: a setup phase, then an access phase; the register takes it when pready is high.
  task automatic write_idle_limit(input logic [15:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = IDLE_LIMIT_ADDR;
    pwdata  = {16'd0, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    cur_idle_limit = value;
  endtask

  function automatic logic [14:0] pick_length();
    return ($urandom_range(7) == 0) ? 15'd0 : 15'($urandom);
  endfunction

  // Up to one window's worth of consecutive sequences from the stream base, sent in
  // order, shuffled or reversed, mixed with duplicates, stray packets and ticks.
  // Reversed full windows park every successor and force the longest drain.
  task automatic send_window_block();
    int  span;
    int  order [WINDOW];
    int  pick;
    int  swap;
    int  noise;
    bit  closed;
    bit  aborted;
    pick = $urandom_range(7);
    if (pick == 0) span = WINDOW;
    else if (pick == 1) span = $urandom_range(9, WINDOW - 1);
    else span = $urandom_range(1, 8);
    pick = $urandom_range(2);
    for (int i = 0; i < span; i++) order[i] = (pick == 2) ? span - 1 - i : i;
    if (pick == 1) begin
      for (int i = span - 1; i > 0; i--) begin
        noise    = $urandom_range(i);
        swap     = order[i];
        order[i] = order[noise];
        order[noise] = swap;
      end
    end
    aborted = 1'b0;
    for (int i = 0; i < span; i++) begin
      if ($urandom_range(9) == 0) begin
        noise = $urandom_range(2);
        // stray packet: anywhere, behind the window, or past its far end
        if (noise == 0)
          send_packet($urandom, 16'($urandom), pick_length());
        else if (noise == 1)
          send_packet(stream_base - 32'd1 - 32'($urandom_range(100)),
                      16'($urandom), pick_length());
        else
          send_packet(stream_base + 32'(span + WINDOW) + 32'($urandom_range(1000)),
                      16'($urandom), pick_length());
      end
      if ($urandom_range(11) == 0) begin
        send_ticks($urandom_range(1, 3), closed);
        if (closed) begin
          aborted = 1'b1;
          break;
        end
      end
      send_packet(stream_base + 32'(order[i]), 16'($urandom), pick_length());
      if ($urandom_range(9) == 0)
        send_packet(stream_base + 32'(order[$urandom_range(i)]), 16'($urandom),
                    pick_length());
    end
    if (!aborted) stream_base = stream_base + 32'(span);
  endtask

  initial begin
    bit closed;
    int phase_start;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst_n    = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part at the reset idle limit.
    send_ticks(1, closed);                              // tick on a closed session
    send_packet(32'd0, 16'hFFFF, 15'h7FFF);             // in order, widest fields
    send_packet(32'd0, 16'h1234, 15'd1);                // behind the window
    send_packet(32'd3, 16'h0003, 15'd3);                // park
    send_packet(32'd3, 16'hBEEF, 15'd9);                // duplicate of a parked slot
    send_packet(32'd2, 16'h0002, 15'd0);                // park an empty payload
    send_packet(32'd32, 16'h0020, 15'd32);              // far edge of the window
    send_packet(32'd33, 16'h0021, 15'd33);              // one past the window
    send_packet(32'hFFFF_FFFF, 16'h0000, 15'd0);        // just behind the window, across the sequence wrap
    send_ticks(3, closed);
    send_packet(32'd1, 16'h5555, 15'h2AAA);             // in order, drains 2 and 3
    send_packet(32'd4, 16'h00A4, 15'd0);                // in order, empty payload
    send_packet(32'hAAAA_AAAA, 16'hAAAA, 15'h5555);
    send_packet(32'h5555_5555, 16'h5555, 15'h2AAA);

    // Shortest idle limit: every tick on an open session closes it.
    wait_for_results();
    write_idle_limit(16'd1);
    send_ticks(2, closed);                              // close, then tick while closed
    send_packet(32'd5, 16'h0505, 15'd5);                // fresh session, ack wraps
    send_ticks(1, closed);
    send_packet(32'd0, 16'h0600, 15'd0);
    send_ticks(1, closed);

    // Random phases, one idle limit each; idle pattern changes every two phases.
    for (int phase = 0; phase < 6; phase++) begin
      wait_for_results();
      write_idle_limit(limit_plan[phase]);
      if (phase == 2) begin
        send_idle_pct = 48;
        recv_idle_pct = 17;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_start = data_sent;
      while (data_sent - phase_start < PHASE_ITEMS) begin
        send_window_block();
        if ($urandom_range(4) == 0) begin
          // idle burst, sometimes long enough to close the session
          if (cur_idle_limit <= 100 && $urandom_range(1) == 0)
            send_ticks(cur_idle_limit, closed);
          else
            send_ticks($urandom_range(1, 4), closed);
        end
        if ($urandom_range(15) == 0) wait_for_results();
      end
    end

    wait_for_results();
    if (wrong_results == 0 && awaited_count == 0) begin
      $display("reorder_buffer_cumulative_ack_unit: match");
    end else begin
      $display("reorder_buffer_cumulative_ack_unit: mismatch");
    end
    $finish;
  end

endmodule
